// ===== rtl/core/plc_pkg.sv =====
// Package for the positional list store: request, status and cell command types.
// Used by plc_cell and positional_list_store. No dependencies.
package plc_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned ReqW = 3;
  localparam int unsigned PosW = 7;
  localparam int unsigned ValW = 32;
  localparam int unsigned CntW = 7;
  localparam int unsigned StW  = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_INS_AT,
    REQ_DEL_AT,
    REQ_INS_FIRST,
    REQ_INS_LAST,
    REQ_DEL_FIRST,
    REQ_DEL_LAST,
    REQ_READ_AT
  } req_e;

  typedef enum logic [StW-1:0] {
    ST_OK,
    ST_BADPOS,
    ST_FULL,
    ST_EMPTY
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_RD_LOAD,
    CELL_RD_SHIFT
  } cell_op_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e                op;
    logic [PosW-1:0]         idx;
    logic signed [ValW-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== rtl/core/positional_list_store.sv =====
// Positional list store: top level with request decode, cell chain and result register.
// Depends on plc_pkg and plc_cell.
//
// Usage:
//   Request channel in_valid_i / in_stall_o carries req_type_i, position_i and
//   value_i; a transfer happens when valid is high and stall is low. Result channel
//   out_valid_o / out_stall_i carries status_o, entry_count_o and read_value_o, one
//   result per request, in request order.
//   Inserts and deletes: every cell behind the position moves to its neighbor in
//   the same cycle, so the result appears in the cycle after the transfer and a new
//   request may follow in the next cycle unless out_stall_i holds that result.
//   read_at at position p: all cells copy their entry into a readout carry, which
//   then shifts one cell toward the head each cycle; the result is loaded when the
//   carry from position p reaches the head, and in_stall_o stays high meanwhile.
//   Reset clears the count and the result valid flag; entries hold no reset value.
//   While out_stall_i holds a waiting result, the result stays stable and
//   in_stall_o is high.
module positional_list_store #(
  parameter int unsigned DEPTH = plc_pkg::DepthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [plc_pkg::ReqW-1:0]         req_type_i,
  input  logic [plc_pkg::PosW-1:0]         position_i,
  input  logic signed [plc_pkg::ValW-1:0]  value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [plc_pkg::StW-1:0]          status_o,
  output logic [plc_pkg::CntW-1:0]         entry_count_o,
  output logic signed [plc_pkg::ValW-1:0]  read_value_o
);
  import plc_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic                   state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdxW-1:0]        rd_cnt_q, rd_cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [StW-1:0]         status_q, status_d;
  logic [CntW-1:0]        ocount_q, ocount_d;
  logic signed [ValW-1:0] rdval_q, rdval_d;

  logic                   in_acc, rd_done, out_load, full, empty;
  logic [CntW:0]          n_ext, pos_ext;
  logic [PosW-1:0]        pos_m1;
  req_e                   req;
  status_e                dec_status;
  cell_op_e               dec_op;
  logic [PosW-1:0]        dec_idx;
  logic [CntW-1:0]        dec_count;
  logic                   rd_start;
  cell_cmd_t              cmd;

  logic signed [ValW-1:0] entries [DEPTH];
  logic signed [ValW-1:0] carries [DEPTH];

  assign in_stall_o = (state_q == StRead) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign req     = req_e'(req_type_i);
  assign n_ext   = {1'b0, count_q};
  assign pos_ext = (CntW + 1)'(position_i);
  assign pos_m1  = position_i - PosW'(1);
  assign full    = count_q >= CntW'(DEPTH);
  assign empty   = count_q == '0;

  always_comb begin
    dec_status = ST_OK;
    dec_op     = CELL_HOLD;
    dec_idx    = '0;
    dec_count  = count_q;
    rd_start   = 1'b0;
    unique case (req)
      REQ_INS_AT: begin
        if (position_i == '0 || pos_ext > n_ext + (CntW + 1)'(1)) begin
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = CELL_INS;
          dec_idx   = pos_m1;
          dec_count = count_q + CntW'(1);
        end
      end
      REQ_DEL_AT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (position_i == '0 || pos_ext > n_ext) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_op    = CELL_DEL;
          dec_idx   = pos_m1;
          dec_count = count_q - CntW'(1);
        end
      end
      REQ_INS_FIRST, REQ_INS_LAST: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_op    = CELL_INS;
          dec_idx   = (req == REQ_INS_FIRST) ? '0 : PosW'(count_q);
          dec_count = count_q + CntW'(1);
        end
      end
      REQ_DEL_FIRST, REQ_DEL_LAST: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_op    = CELL_DEL;
          dec_idx   = (req == REQ_DEL_FIRST) ? '0 : PosW'(count_q - CntW'(1));
          dec_count = count_q - CntW'(1);
        end
      end
      REQ_READ_AT: begin
        if (position_i == '0 || pos_ext > n_ext) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_op   = CELL_RD_LOAD;
          rd_start = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rd_done  = (state_q == StRead) && (rd_cnt_q == '0) && !(out_valid_q && out_stall_i);
  assign out_load = (in_acc && !rd_start) || rd_done;

  always_comb begin
    cmd.value = value_i;
    cmd.idx   = dec_idx;
    cmd.op    = CELL_HOLD;
    if (state_q == StRead) begin
      if (rd_cnt_q != '0) begin
        cmd.op = CELL_RD_SHIFT;
      end
    end else if (in_acc) begin
      cmd.op = dec_op;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ValW-1:0] left, right, carry_right;
    if (i == 0) begin : g_head
      assign left = value_i;
    end else begin : g_body
      assign left = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right       = '0;
      assign carry_right = '0;
    end else begin : g_next
      assign right       = entries[i+1];
      assign carry_right = carries[i+1];
    end
    plc_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .left_i        (left),
      .right_i       (right),
      .carry_right_i (carry_right),
      .entry_o       (entries[i]),
      .carry_o       (carries[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_cnt_d    = rd_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    ocount_d    = ocount_q;
    rdval_d     = rdval_q;
    if (state_q == StRead) begin
      if (rd_cnt_q != '0) begin
        rd_cnt_d = rd_cnt_q - IdxW'(1);
      end else if (rd_done) begin
        state_d  = StIdle;
        status_d = ST_OK;
        ocount_d = count_q;
        rdval_d  = carries[0];
      end
    end else if (in_acc) begin
      count_d = dec_count;
      if (rd_start) begin
        state_d  = StRead;
        rd_cnt_d = IdxW'(pos_m1);
      end else begin
        status_d = dec_status;
        ocount_d = dec_count;
        rdval_d  = '0;
      end
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    ocount_q <= ocount_d;
    rdval_q  <= rdval_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = ocount_q;
  assign read_value_o  = rdval_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_read_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> in_stall_o)
    else $error("request taken during readout");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(count_q))
    else $error("count changed without a transfer");

  a_read_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && rd_start) |=> (state_q == StRead))
    else $error("valid read did not start readout");

endmodule

// ===== rtl/core/plc_cell.sv =====
// One storage cell of the list chain: holds one entry and one readout carry.
// Depends on plc_pkg.
module plc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                             clk_i,
  input  plc_pkg::cell_cmd_t               cmd_i,
  input  logic signed [plc_pkg::ValW-1:0]  left_i,
  input  logic signed [plc_pkg::ValW-1:0]  right_i,
  input  logic signed [plc_pkg::ValW-1:0]  carry_right_i,
  output logic signed [plc_pkg::ValW-1:0]  entry_o,
  output logic signed [plc_pkg::ValW-1:0]  carry_o
);
  import plc_pkg::*;

  localparam logic [PosW-1:0] MyIdx = PosW'(IDX);

  logic signed [ValW-1:0] entry_q, entry_d;
  logic signed [ValW-1:0] carry_q, carry_d;

  always_comb begin
    entry_d = entry_q;
    carry_d = carry_q;
    unique case (cmd_i.op)
      CELL_INS: begin
        if (MyIdx > cmd_i.idx) begin
          entry_d = left_i;
        end else if (MyIdx == cmd_i.idx) begin
          entry_d = cmd_i.value;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= cmd_i.idx) begin
          entry_d = right_i;
        end
      end
      CELL_RD_LOAD:  carry_d = entry_q;
      CELL_RD_SHIFT: carry_d = carry_right_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    carry_q <= carry_d;
  end

  assign entry_o = entry_q;
  assign carry_o = carry_q;

endmodule

// ===== test/testbench.sv =====
// Testbench for positional_list_store: a shadow list predicts status, count and read value
// for every request transfer and checks each result transfer in order.
// Depends on plc_pkg and the positional_list_store RTL.
`timescale 1ns / 100ps

module testbench;
  import plc_pkg::*;

  localparam logic [ReqW-1:0] ReqUnused = 3'd7;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned RandomItems = 1725;
  localparam int unsigned HoldAt = 600;
  localparam int unsigned PauseAt = 1000;
  localparam int unsigned CalmAt = 1500;

  typedef struct {
    status_e                status;
    logic [CntW-1:0]        count;
    logic signed [ValW-1:0] rd_value;
  } list_result_t;

  class list_shadow;
    logic signed [ValW-1:0] entries [DepthDefault];
    int unsigned held;
    list_result_t owed[$];
    int unsigned fails;

    function void place(int unsigned idx, logic signed [ValW-1:0] val);
      int unsigned i;
      for (i = held; i > idx; i--) entries[i] = entries[i-1];
      entries[idx] = val;
      held++;
    endfunction

    function void remove(int unsigned idx);
      int unsigned i;
      for (i = idx; i + 1 < held; i++) entries[i] = entries[i+1];
      held--;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void note_request(logic [ReqW-1:0] req, logic [PosW-1:0] pos,
                               logic signed [ValW-1:0] val);
      list_result_t r;
      int unsigned p;
      r.status = ST_OK;
      r.rd_value = '0;
      p = pos;
      case (req)
        REQ_INS_AT: begin
          if (p < 1 || p > held + 1) r.status = ST_BADPOS;
          else if (held >= DepthDefault) r.status = ST_FULL;
          else place(p - 1, val);
        end
        REQ_DEL_AT: begin
          if (held == 0) r.status = ST_EMPTY;
          else if (p < 1 || p > held) r.status = ST_BADPOS;
          else remove(p - 1);
        end
        REQ_INS_FIRST, REQ_INS_LAST: begin
          if (held >= DepthDefault) r.status = ST_FULL;
          else place((req == REQ_INS_FIRST) ? 0 : held, val);
        end
        REQ_DEL_FIRST, REQ_DEL_LAST: begin
          if (held == 0) r.status = ST_EMPTY;
          else remove((req == REQ_DEL_FIRST) ? 0 : held - 1);
        end
        REQ_READ_AT: begin
          if (p < 1 || p > held) r.status = ST_BADPOS;
          else r.rd_value = entries[p-1];
        end
        default: ;
      endcase
      r.count = CntW'(held);
      owed.push_back(r);
    endfunction

    function void check_result(logic [StW-1:0] st, logic [CntW-1:0] cnt,
                               logic signed [ValW-1:0] rd);
      list_result_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result status %0d count %0d value %0d", $time, st, cnt, rd);
        fails++;
      end else begin
        e = owed.pop_front();
        if (st !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, st);
          fails++;
        end
        if (cnt !== e.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, e.count, cnt);
          fails++;
        end
        if (rd !== e.rd_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time, e.rd_value, rd);
          fails++;
        end
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [ReqW-1:0]        req_type_i;
  logic [PosW-1:0]        position_i;
  logic signed [ValW-1:0] value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [StW-1:0]         status_o;
  logic [CntW-1:0]        entry_count_o;
  logic signed [ValW-1:0] read_value_o;

  list_shadow ledger = new;
  bit calm;
  bit hold_request;
  int unsigned quiet_cycles;

  positional_list_store u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .read_value_o (read_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic sender_idle(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic offer(logic [ReqW-1:0] req, logic [PosW-1:0] pos,
                       logic signed [ValW-1:0] val);
    if (!calm && $urandom_range(0, 3) == 0) sender_idle($urandom_range(1, 18));
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(req, pos, val);
  endtask

  function automatic logic [PosW-1:0] pick_position(int unsigned top);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return PosW'(top + 1);
      2: return PosW'($urandom_range(0, 127));
      3: return '1;
      4: return PosW'(top);
      default: return (top == 0) ? PosW'(1) : PosW'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic signed [ValW-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // mode 0 grows the list, 1 shrinks it, 2 mixes
  function automatic logic [ReqW-1:0] pick_request(int unsigned mode);
    int unsigned r;
    int unsigned ins_share;
    int unsigned del_share;
    r = $urandom_range(0, 99);
    ins_share = (mode == 0) ? 70 : (mode == 1) ? 15 : 40;
    del_share = (mode == 1) ? 70 : (mode == 0) ? 15 : 40;
    if (r < ins_share) begin
      case ($urandom_range(0, 2))
        0: return REQ_INS_AT;
        1: return REQ_INS_FIRST;
        default: return REQ_INS_LAST;
      endcase
    end else if (r < ins_share + del_share) begin
      case ($urandom_range(0, 2))
        0: return REQ_DEL_AT;
        1: return REQ_DEL_FIRST;
        default: return REQ_DEL_LAST;
      endcase
    end else if (r < 98) begin
      return REQ_READ_AT;
    end else begin
      return ReqUnused;
    end
  endfunction

  // result side: random stall bursts, one long hold on request
  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (299) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 18);
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        burst = $urandom_range(1, 18);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ledger.check_result(status_o, entry_count_o, read_value_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned mode;
    int unsigned seg_left;
    logic [ReqW-1:0] req;
    in_valid_i = 1'b0;
    req_type_i = '0;
    position_i = '0;
    value_i    = '0;
    calm = 1'b0;
    hold_request = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list, bad positions, extremes, every request code
    offer(REQ_DEL_FIRST, 7'd0, '0);
    offer(REQ_DEL_LAST, 7'd0, '0);
    offer(REQ_DEL_AT, 7'd0, '0);
    offer(REQ_DEL_AT, 7'd127, '0);
    offer(REQ_READ_AT, 7'd1, '0);
    offer(REQ_READ_AT, 7'd0, '0);
    offer(REQ_INS_AT, 7'd0, 32'sd5);
    offer(REQ_INS_AT, 7'd2, 32'sd6);
    offer(REQ_INS_AT, 7'd1, 32'sh8000_0000);
    offer(REQ_INS_FIRST, 7'd0, 32'sh7fff_ffff);
    offer(REQ_INS_LAST, 7'd127, '1);
    offer(REQ_INS_AT, 7'd4, '0);
    offer(REQ_INS_AT, 7'd2, 32'sh5555_5555);
    offer(REQ_INS_AT, 7'd127, 32'sh2aaa_aaaa);
    offer(REQ_READ_AT, 7'd1, '0);
    offer(REQ_READ_AT, 7'd5, '0);
    offer(REQ_READ_AT, 7'd6, '0);
    offer(REQ_READ_AT, 7'd127, '0);
    offer(REQ_DEL_AT, 7'd0, '0);
    offer(REQ_DEL_AT, 7'd6, '0);
    offer(REQ_DEL_AT, 7'd3, '0);
    offer(ReqUnused, 7'd127, 32'shaaaa_aaaa);
    offer(REQ_DEL_FIRST, 7'd0, '0);
    offer(REQ_DEL_LAST, 7'd0, '0);
    offer(REQ_READ_AT, 7'd2, '0);

    mode = 0;
    seg_left = $urandom_range(100, 200);
    for (n = 0; n < RandomItems; n++) begin
      if (seg_left == 0) begin
        mode = (mode == 0) ? 2 : (mode == 2) ? 1 : 0;
        seg_left = $urandom_range(100, 200);
      end
      seg_left--;
      if (n == HoldAt) hold_request = 1'b1;
      if (n == PauseAt) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (ledger.pending() != 0) @(negedge clk_i);
      end
      if (n == CalmAt) calm = 1'b1;
      req = pick_request(mode);
      offer(req,
            pick_position((req == REQ_INS_AT) ? ledger.held + 1 : ledger.held),
            pick_value());
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
    if (ledger.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
